>>> rtl/bcspg_pkg.sv
// Shared types and constants of the battery charge-state percentage gauge.
package bcspg_pkg;

   localparam int TABLE_DEPTH = 8;
   localparam int SLACK_MV    = 10;

   typedef enum logic [1:0] {
      TBL_DISCHARGE = 2'd0,
      TBL_CHARGE    = 2'd1,
      TBL_CURRENT   = 2'd2
   } tbl_sel_type;

   typedef enum logic [1:0] {
      ST_DISCHARGE = 2'd0,
      ST_CHARGE    = 2'd1,
      ST_TRICKLE   = 2'd2,
      ST_FULL      = 2'd3
   } chg_state_type;

   localparam logic [2:0] REG_FULL_TARGET    = 3'd0;
   localparam logic [2:0] REG_TRICKLE_TARGET = 3'd1;
   localparam logic [2:0] REG_TRICKLE_MV     = 3'd2;
   localparam logic [2:0] REG_FULL_MV        = 3'd3;
   localparam logic [2:0] REG_FULL_RULE      = 3'd4;
   localparam logic [2:0] REG_CUR_SENSE      = 3'd5;
   localparam logic [2:0] REG_VPOINTS        = 3'd6;
   localparam logic [2:0] REG_CPOINTS        = 3'd7;

endpackage

>>> rtl/battery_charge_state_percent_gauge_top.sv
// Battery charge-state and percentage gauge, top level.
//
// Input channel (req_*): each beat is a measurement sample (kind 0) or a
// table entry write (kind 1). A beat is taken when req_valid is high and
// req_stall is low; req_stall stays high while a sample is being worked on.
// Result channel (rsp_*): one beat per sample, none for a table write; the
// result register holds its beat while rsp_stall is high. The next sample
// is still taken, but it waits in its last step until the held beat leaves.
// Config port (csr_*): register index and data, written when csr_valid and
// csr_ready are high; csr_ready is always high.
// A sample walks the selected voltage table, one entry at a time
// (N entries in use at most; in trickle charge without current sensing it
// walks all N unless the voltage is at or below the first level). It may
// then walk the current table (M entries in use) or run a 23-step
// restoring divider for the interpolation. The next item can be taken in
// the cycle in which the result beat becomes valid. A table write is
// stored when it is taken and gives no result beat.
// Reset clears the detector, the shown percent and the sequencer and loads
// the register defaults; table contents stay unknown until written.
module battery_charge_state_percent_gauge_top #(
   parameter int TABLE_DEPTH = bcspg_pkg::TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic        req_plugged_in,
   input  logic [12:0] req_voltage_mv,
   input  logic [11:0] req_current_ma,
   input  logic [1:0]  req_table_select,
   input  logic [2:0]  req_table_index,
   input  logic [12:0] req_point_level,
   input  logic [6:0]  req_point_percent,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_charge_state,
   output logic [6:0]  rsp_shown_percent,
   output logic [6:0]  rsp_direct_percent,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_VREAD = 7'b0000010,
      S_VCHK  = 7'b0000100,
      S_CREAD = 7'b0001000,
      S_CCHK  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } fsm_type;

   // configuration registers
   logic [15:0] full_tgt_ff, trk_tgt_ff;
   logic [12:0] trk_mv_ff, full_mv_ff;
   logic        full_rule_ff, cur_sense_ff;
   logic [3:0]  vpts_ff, cpts_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_tgt_ff  <= 16'd10;
         trk_tgt_ff   <= 16'd10;
         trk_mv_ff    <= 13'd4100;
         full_mv_ff   <= 13'd4200;
         full_rule_ff <= 1'b1;
         cur_sense_ff <= 1'b0;
         vpts_ff      <= 4'd8;
         cpts_ff      <= 4'd8;
      end else if (csr_valid) begin
         case (csr_index)
            bcspg_pkg::REG_FULL_TARGET:    full_tgt_ff  <= csr_data;
            bcspg_pkg::REG_TRICKLE_TARGET: trk_tgt_ff   <= csr_data;
            bcspg_pkg::REG_TRICKLE_MV:     trk_mv_ff    <= csr_data[12:0];
            bcspg_pkg::REG_FULL_MV:        full_mv_ff   <= csr_data[12:0];
            bcspg_pkg::REG_FULL_RULE:      full_rule_ff <= csr_data[0];
            bcspg_pkg::REG_CUR_SENSE:      cur_sense_ff <= csr_data[0];
            bcspg_pkg::REG_VPOINTS:        vpts_ff      <= csr_data[3:0];
            bcspg_pkg::REG_CPOINTS:        cpts_ff      <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // table memories: level and percent per entry
   logic [19:0] dis_mem [TABLE_DEPTH];
   logic [19:0] chg_mem [TABLE_DEPTH];
   logic [19:0] cur_mem [TABLE_DEPTH];
   logic [19:0] vrd_ff, crd_ff;

   logic [IW-1:0] idx_ff, idx_in;
   logic          plug_ff;
   logic [12:0]   volt_ff;
   logic [11:0]   cur_ff;
   fsm_type       st_ff, st_in;

   logic acc;
   assign acc = req_valid && !req_stall;
   assign req_stall = (st_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (acc && req_kind && 32'(req_table_index) < TABLE_DEPTH) begin
         case (req_table_select)
            bcspg_pkg::TBL_DISCHARGE:
               dis_mem[IW'(req_table_index)] <= {req_point_level, req_point_percent};
            bcspg_pkg::TBL_CHARGE:
               chg_mem[IW'(req_table_index)] <= {req_point_level, req_point_percent};
            bcspg_pkg::TBL_CURRENT:
               cur_mem[IW'(req_table_index)] <= {req_point_level, req_point_percent};
            default: ;
         endcase
      end
      vrd_ff <= plug_ff ? chg_mem[idx_ff] : dis_mem[idx_ff];
      crd_ff <= cur_mem[idx_ff];
   end

   // clamped point counts
   logic [CW-1:0] n_c, m_c;
   always_comb begin
      if (vpts_ff < 4'd2)                n_c = CW'(2);
      else if (32'(vpts_ff) > TABLE_DEPTH) n_c = CW'(TABLE_DEPTH);
      else                               n_c = CW'(vpts_ff);
      if (cpts_ff < 4'd1)                m_c = CW'(1);
      else if (32'(cpts_ff) > TABLE_DEPTH) m_c = CW'(TABLE_DEPTH);
      else                               m_c = CW'(cpts_ff);
   end

   // full-charge detector, updated at sample acceptance
   logic [15:0] fcnt_ff, tcnt_ff;
   logic [12:0] peak_ff;
   logic [11:0] least_ff;
   logic [15:0] fcnt_in, tcnt_in;
   logic [12:0] peak_in;
   logic [11:0] least_in;
   logic signed [14:0] sv;

   always_comb begin
      sv = 15'(signed'({2'b00, req_voltage_mv}));
      fcnt_in = fcnt_ff; tcnt_in = tcnt_ff; peak_in = peak_ff; least_in = least_ff;
      if (!req_plugged_in) begin
         fcnt_in = '0; tcnt_in = '0; peak_in = '0; least_in = '0;
      end else begin
         if (tcnt_ff < trk_tgt_ff &&
             sv > 15'(signed'({2'b00, trk_mv_ff})) - 15'sd10)
            tcnt_in = tcnt_ff + 16'd1;
         if (15'(signed'({2'b00, peak_ff})) < sv - 15'sd10) begin
            peak_in = req_voltage_mv; tcnt_in = '0;
         end
         if (cur_sense_ff && (least_ff == '0 || least_ff > req_current_ma)) begin
            least_in = req_current_ma; tcnt_in = '0;
         end
         if (tcnt_in >= trk_tgt_ff ||
             (full_rule_ff && sv >= 15'(signed'({2'b00, full_mv_ff})) - 15'sd10)) begin
            if (fcnt_ff < full_tgt_ff) fcnt_in = fcnt_ff + 16'd1;
         end else fcnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= '0; tcnt_ff <= '0; peak_ff <= '0; least_ff <= '0;
      end else if (acc && !req_kind) begin
         fcnt_ff <= fcnt_in; tcnt_ff <= tcnt_in; peak_ff <= peak_in; least_ff <= least_in;
      end
   end

   // sample datapath registers
   logic [19:0] prev_ff, prev_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [6:0]  pct_ff, pct_in;
   // divider: quotient = step*(hi-lo)/total, then lo +/- quotient
   logic [22:0] num_ff, num_in;      // dividend shifted out msb first
   logic [15:0] den_ff, den_in;
   logic [16:0] rem_ff, rem_in;
   logic [6:0]  quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [6:0]  lo_ff, lo_in;
   logic        neg_ff, neg_in;
   logic [6:0]  held_ff, held_in;
   logic        hv_ff, hv_in;
   logic        ov_ff, ov_in;
   logic [1:0]  os_ff;
   logic [6:0]  osh_ff, odp_ff;

   logic [1:0]  state_c;
   always_comb begin
      if (!plug_ff)                state_c = bcspg_pkg::ST_DISCHARGE;
      else if (fcnt_ff >= full_tgt_ff) state_c = bcspg_pkg::ST_FULL;
      else if (fcnt_ff != '0)      state_c = bcspg_pkg::ST_TRICKLE;
      else                         state_c = bcspg_pkg::ST_CHARGE;
   end

   // set up a division of step*(hi-lo) by total with step already clamped
   logic [15:0] d_step, d_tot;
   logic [6:0]  d_lo, d_hi;
   logic [6:0]  d_diff;
   logic [22:0] d_prod;

   logic [16:0] rem_sh;
   logic [6:0]  shown_c, fin_c;

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; prev_in = prev_ff; pos_in = pos_ff;
      pct_in = pct_ff; num_in = num_ff; den_in = den_ff; rem_in = rem_ff;
      quo_in = quo_ff; cnt_in = cnt_ff; lo_in = lo_ff; neg_in = neg_ff;
      held_in = held_ff; hv_in = hv_ff; ov_in = ov_ff;
      d_step = '0; d_tot = 16'd1; d_lo = '0; d_hi = '0; d_diff = '0; d_prod = '0;
      rem_sh = '0; shown_c = '0; fin_c = '0;
      if (ov_ff && !rsp_stall) ov_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (acc && !req_kind) begin
               idx_in = '0; pos_in = '0; st_in = S_VREAD;
            end
         end
         S_VREAD: st_in = S_VCHK;   // read data registered this cycle
         S_VCHK: begin
            // walk: stop at first entry with volt <= level, or at entry n - 1
            if (volt_ff <= vrd_ff[19:7] || pos_ff == n_c - CW'(1)) begin
               if (volt_ff <= vrd_ff[19:7] && pos_ff == '0) begin
                  pct_in = '0; st_in = S_OUT;
               end else if ((!plug_ff && volt_ff > vrd_ff[19:7]) ||
                            state_c == bcspg_pkg::ST_FULL) begin
                  pct_in = 7'd100; st_in = S_OUT;
               end else if (state_c == bcspg_pkg::ST_TRICKLE) begin
                  if (cur_sense_ff) begin
                     idx_in = '0; pos_in = '0; st_in = S_CREAD;
                  end else if (pos_ff != n_c - CW'(1)) begin
                     // trickle ramp uses the last segment: walk on to it
                     prev_in = vrd_ff;
                     pos_in = pos_ff + CW'(1);
                     idx_in = IW'(pos_ff + CW'(1));
                     st_in = S_VREAD;
                  end else begin
                     // last segment, step = full counter, total = target
                     d_lo = prev_ff[6:0]; d_hi = vrd_ff[6:0];
                     d_tot = (full_tgt_ff == '0) ? 16'd1 : full_tgt_ff;
                     d_step = (fcnt_ff > d_tot) ? d_tot : fcnt_ff;
                     st_in = S_DIV;
                  end
               end else begin
                  // segment between previous and this entry
                  if (vrd_ff[19:7] <= prev_ff[19:7] || volt_ff >= vrd_ff[19:7]) begin
                     pct_in = vrd_ff[6:0]; st_in = S_OUT;
                  end else if (volt_ff <= prev_ff[19:7]) begin
                     pct_in = prev_ff[6:0]; st_in = S_OUT;
                  end else begin
                     d_lo = prev_ff[6:0]; d_hi = vrd_ff[6:0];
                     d_step = 16'(volt_ff - prev_ff[19:7]);
                     d_tot = 16'(vrd_ff[19:7] - prev_ff[19:7]);
                     st_in = S_DIV;
                  end
               end
               if (st_in == S_DIV) begin
                  neg_in = (d_hi < d_lo);
                  d_diff = neg_in ? d_lo - d_hi : d_hi - d_lo;
                  d_prod = 23'(d_step) * 23'(d_diff);
                  num_in = d_prod; den_in = d_tot; rem_in = '0; quo_in = '0;
                  cnt_in = 5'd23; lo_in = d_lo;
               end
            end else begin
               prev_in = vrd_ff;
               pos_in = pos_ff + CW'(1);
               idx_in = IW'(pos_ff + CW'(1));
               st_in = S_VREAD;
            end
         end
         S_CREAD: st_in = S_CCHK;
         S_CCHK: begin
            if ({1'b0, cur_ff} > crd_ff[19:7] || pos_ff == m_c - CW'(1)) begin
               pct_in = crd_ff[6:0]; st_in = S_OUT;
            end else begin
               pos_in = pos_ff + CW'(1);
               idx_in = IW'(pos_ff + CW'(1));
               st_in = S_CREAD;
            end
         end
         S_DIV: begin
            // restoring divider, one quotient bit a cycle
            rem_sh = {rem_ff[15:0], num_ff[22]};
            num_in = {num_ff[21:0], 1'b0};
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               quo_in = {quo_ff[5:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[5:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               pct_in = neg_ff ? lo_ff - quo_in : lo_ff + quo_in;
               st_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ov_ff || !rsp_stall) begin
               fin_c = (pct_ff > 7'd100) ? 7'd100 : pct_ff;
               shown_c = (plug_ff && state_c != bcspg_pkg::ST_FULL && fin_c == 7'd100)
                         ? 7'd99 : fin_c;
               if (!hv_ff) begin
                  held_in = shown_c; hv_in = 1'b1;
               end else if (plug_ff) begin
                  if (shown_c > held_ff) held_in = shown_c;
               end else if (shown_c < held_ff) held_in = shown_c;
               ov_in = 1'b1;
               pct_in = fin_c;
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; hv_ff <= 1'b0; held_ff <= '0; ov_ff <= 1'b0;
      end else begin
         st_ff <= st_in; hv_ff <= hv_in; held_ff <= held_in; ov_ff <= ov_in;
      end
      idx_ff <= idx_in; prev_ff <= prev_in; pos_ff <= pos_in; pct_ff <= pct_in;
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in;
      cnt_ff <= cnt_in; lo_ff <= lo_in; neg_ff <= neg_in;
      if (acc && !req_kind) begin
         plug_ff <= req_plugged_in; volt_ff <= req_voltage_mv; cur_ff <= req_current_ma;
      end
      if (st_ff == S_OUT && (!ov_ff || !rsp_stall)) begin
         os_ff <= state_c; osh_ff <= held_in; odp_ff <= pct_in;
      end
   end

   assign rsp_valid          = ov_ff;
   assign rsp_charge_state   = os_ff;
   assign rsp_shown_percent  = osh_ff;
   assign rsp_direct_percent = odp_ff;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the battery charge-state percentage gauge.
module tb_top;

   localparam logic [1:0] TBL_UNUSED = 2'd3;   // select with no table behind it
   localparam int         SETTLE     = 40;     // cycles for an in-flight beat to finish

   typedef struct packed {
      logic        kind;
      logic        plugged;
      logic [12:0] volt;
      logic [11:0] cur;
      logic [1:0]  sel;
      logic [2:0]  idx;
      logic [12:0] lvl;
      logic [6:0]  pcnt;
   } gauge_item_type;

   typedef struct packed {
      logic [1:0] state;
      logic [6:0] shown;
      logic [6:0] direct;
   } gauge_result_type;

   localparam int ITEM_W = $bits(gauge_item_type);

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_kind = 0;
   logic        req_plugged_in = 0;
   logic [12:0] req_voltage_mv = 0;
   logic [11:0] req_current_ma = 0;
   logic [1:0]  req_table_select = 0;
   logic [2:0]  req_table_index = 0;
   logic [12:0] req_point_level = 0;
   logic [6:0]  req_point_percent = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_charge_state;
   logic [6:0]  rsp_shown_percent;
   logic [6:0]  rsp_direct_percent;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [15:0] csr_data = 0;

   battery_charge_state_percent_gauge_top uut (.*);

   always #10 clock = ~clock;

   // stimulus and expectation stores
   gauge_item_type   pending_q[$];
   gauge_result_type expected_q[$];
   gauge_item_type   drv_item;
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   logic          hold_request = 0;
   int            hold_left = 0;
   int            errors = 0;
   int            n_samples = 0, n_writes = 0, n_results = 0, n_full = 0;

   // predictor copy of registers and state
   logic [15:0] m_full_target, m_trickle_target;
   logic [12:0] m_trickle_mv, m_full_mv;
   logic        m_full_rule, m_cur_sense;
   logic [3:0]  m_vpoints, m_cpoints;
   logic [15:0] full_cnt, trickle_cnt;
   logic [12:0] peak_mv;
   logic [11:0] least_ma;
   logic [6:0]  held_pct;
   logic        held_ok;
   logic [12:0] lvl_tab[3][bcspg_pkg::TABLE_DEPTH];
   logic [6:0]  pct_tab[3][bcspg_pkg::TABLE_DEPTH];

   function automatic int blend(int t, int k, int step, int total);
      int lo, hi;
      lo = int'(pct_tab[t][k-1]);
      hi = int'(pct_tab[t][k]);
      if (total == 0) total = 1;
      if (step > total) step = total;
      return lo + (step * (hi - lo)) / total;
   endfunction

   // gauge prediction for one accepted beat
   function automatic void gauge_predict(gauge_item_type it);
      int v, c, n, m, i, t, pct, shown, lo, hi;
      bcspg_pkg::chg_state_type st;
      gauge_result_type r;
      if (it.kind) begin
         if (it.sel != TBL_UNUSED) begin
            lvl_tab[it.sel][it.idx] = it.lvl;
            pct_tab[it.sel][it.idx] = it.pcnt;
         end
         return;
      end
      v = int'(it.volt);
      c = int'(it.cur);
      // full-charge detector
      if (!it.plugged) begin
         trickle_cnt = '0; full_cnt = '0; peak_mv = '0; least_ma = '0;
      end else begin
         if (trickle_cnt < m_trickle_target &&
             v > int'(m_trickle_mv) - bcspg_pkg::SLACK_MV)
            trickle_cnt++;
         if (int'(peak_mv) < v - bcspg_pkg::SLACK_MV) begin
            peak_mv = it.volt; trickle_cnt = '0;
         end
         if (m_cur_sense && (least_ma == '0 || least_ma > it.cur)) begin
            least_ma = it.cur; trickle_cnt = '0;
         end
         if (trickle_cnt >= m_trickle_target ||
             (m_full_rule && v >= int'(m_full_mv) - bcspg_pkg::SLACK_MV)) begin
            if (full_cnt < m_full_target) full_cnt++;
         end else full_cnt = '0;
      end
      if (!it.plugged) st = bcspg_pkg::ST_DISCHARGE;
      else if (full_cnt >= m_full_target) st = bcspg_pkg::ST_FULL;
      else if (full_cnt != '0) st = bcspg_pkg::ST_TRICKLE;
      else st = bcspg_pkg::ST_CHARGE;
      // direct percent
      n = int'(m_vpoints);
      if (n < 2) n = 2;
      if (n > bcspg_pkg::TABLE_DEPTH) n = bcspg_pkg::TABLE_DEPTH;
      t = it.plugged ? int'(bcspg_pkg::TBL_CHARGE) : int'(bcspg_pkg::TBL_DISCHARGE);
      for (i = 0; i < n; i++) if (v <= int'(lvl_tab[t][i])) break;
      if (i == 0) pct = 0;
      else if ((!it.plugged && i == n) || st == bcspg_pkg::ST_FULL) pct = 100;
      else if (st == bcspg_pkg::ST_TRICKLE) begin
         if (m_cur_sense) begin
            m = int'(m_cpoints);
            if (m < 1) m = 1;
            if (m > bcspg_pkg::TABLE_DEPTH) m = bcspg_pkg::TABLE_DEPTH;
            for (i = 0; i < m; i++)
               if (c > int'(lvl_tab[bcspg_pkg::TBL_CURRENT][i])) break;
            if (i == m) i = m - 1;
            pct = int'(pct_tab[bcspg_pkg::TBL_CURRENT][i]);
         end else pct = blend(t, n - 1, int'(full_cnt), int'(m_full_target));
      end else begin
         if (i >= n) i = n - 1;
         lo = int'(lvl_tab[t][i-1]);
         hi = int'(lvl_tab[t][i]);
         if (hi <= lo || v >= hi) pct = int'(pct_tab[t][i]);
         else if (v <= lo) pct = int'(pct_tab[t][i-1]);
         else pct = blend(t, i, v - lo, hi - lo);
      end
      if (pct > 100) pct = 100;
      // monotonic shown value
      shown = pct;
      if (it.plugged && st != bcspg_pkg::ST_FULL && shown == 100) shown = 99;
      if (!held_ok) begin
         held_pct = 7'(shown); held_ok = 1'b1;
      end else if (it.plugged) begin
         if (shown > int'(held_pct)) held_pct = 7'(shown);
      end else if (shown < int'(held_pct)) held_pct = 7'(shown);
      r.state = st;
      r.shown = held_pct;
      r.direct = 7'(pct);
      expected_q.push_back(r);
   endfunction

   // driver: offers queued beats, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) gauge_predict(drv_item);
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drv_item = pending_q.pop_front();
               req_valid         <= 1'b1;
               req_kind          <= drv_item.kind;
               req_plugged_in    <= drv_item.plugged;
               req_voltage_mv    <= drv_item.volt;
               req_current_ma    <= drv_item.cur;
               req_table_select  <= drv_item.sel;
               req_table_index   <= drv_item.idx;
               req_point_level   <= drv_item.lvl;
               req_point_percent <= drv_item.pcnt;
            end else req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_request) hold_left <= 600;
   end

   // monitor: checks result beats, drives stall
   always @(posedge clock) begin
      gauge_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_results++;
         if (rsp_charge_state == bcspg_pkg::ST_FULL) n_full++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat state=%0d shown=%0d direct=%0d", $time,
                     rsp_charge_state, rsp_shown_percent, rsp_direct_percent);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_charge_state !== e.state) begin
               $display("%0t: charge_state expected %0d actual %0d", $time, e.state,
                        rsp_charge_state);
               errors++;
            end
            if (rsp_shown_percent !== e.shown) begin
               $display("%0t: shown_percent expected %0d actual %0d", $time, e.shown,
                        rsp_shown_percent);
               errors++;
            end
            if (rsp_direct_percent !== e.direct) begin
               $display("%0t: direct_percent expected %0d actual %0d", $time, e.direct,
                        rsp_direct_percent);
               errors++;
            end
         end
      end
      rsp_stall <= !reset && (hold_left != 0 || $urandom_range(99) < stall_pct);
   end

   function automatic void add_sample(logic plugged, int v, int c);
      gauge_item_type it;
      it = ITEM_W'({$urandom, $urandom});
      it.kind = 1'b0;
      it.plugged = plugged;
      it.volt = 13'((v < 0) ? 0 : (v > 8191) ? 8191 : v);
      it.cur = 12'((c < 0) ? 0 : (c > 4095) ? 4095 : c);
      pending_q.push_back(it);
      n_samples++;
   endfunction

   function automatic void add_write(logic [1:0] sel, int idx, int lvl, int pcnt);
      gauge_item_type it;
      it = ITEM_W'({$urandom, $urandom});
      it.kind = 1'b1;
      it.sel = sel;
      it.idx = 3'(idx);
      it.lvl = 13'(lvl);
      it.pcnt = 7'(pcnt);
      pending_q.push_back(it);
      n_writes++;
   endfunction

   task automatic wait_idle();
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         bcspg_pkg::REG_FULL_TARGET:    m_full_target = val;
         bcspg_pkg::REG_TRICKLE_TARGET: m_trickle_target = val;
         bcspg_pkg::REG_TRICKLE_MV:     m_trickle_mv = val[12:0];
         bcspg_pkg::REG_FULL_MV:        m_full_mv = val[12:0];
         bcspg_pkg::REG_FULL_RULE:      m_full_rule = val[0];
         bcspg_pkg::REG_CUR_SENSE:      m_cur_sense = val[0];
         bcspg_pkg::REG_VPOINTS:        m_vpoints = val[3:0];
         default:                       m_cpoints = val[3:0];
      endcase
   endtask

   // random traffic: mostly charge and discharge runs, some noise and rewrites
   task automatic random_traffic(int count);
      int done, len, v, c, k;
      logic plugged;
      done = 0;
      while (done < count) begin
         k = $urandom_range(99);
         if (k < 4) begin
            add_write(2'($urandom_range(3)), $urandom_range(7), $urandom_range(8191),
                      $urandom_range(100));
         end else if (k < 18) begin
            add_sample(1'($urandom_range(1)), $urandom_range(8191), $urandom_range(4095));
            done++;
         end else begin
            plugged = 1'($urandom_range(1));
            len = $urandom_range(5, 40);
            v = plugged ? $urandom_range(3000, 4100) : $urandom_range(3400, 4350);
            c = $urandom_range(200, 3000);
            repeat (len) begin
               v += plugged ? $urandom_range(0, 40) - 5 : 5 - $urandom_range(0, 40);
               c -= $urandom_range(0, 120) - 20;
               add_sample(plugged, v, c);
               done++;
            end
         end
      end
      while (pending_q.size() != 0) @(posedge clock);
   endtask

   // register defaults and detector reset values
   initial begin
      m_full_target = 10; m_trickle_target = 10; m_trickle_mv = 4100; m_full_mv = 4200;
      m_full_rule = 1; m_cur_sense = 0; m_vpoints = 8; m_cpoints = 8;
      full_cnt = 0; trickle_cnt = 0; peak_mv = 0; least_ma = 0; held_pct = 0; held_ok = 0;
   end

   // main sequence
   initial begin
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // fill every table entry so no unwritten entry is ever read
      for (i = 0; i < bcspg_pkg::TABLE_DEPTH; i++) begin
         add_write(bcspg_pkg::TBL_DISCHARGE, i, 3300 + i * 130, i * 100 / 7);
         add_write(bcspg_pkg::TBL_CHARGE, i, (i == 7) ? 4150 : 3400 + i * 110, i * 100 / 7);
         add_write(bcspg_pkg::TBL_CURRENT, i, 1600 - i * 200, 70 + i * 4);
      end
      // directed: field extremes, write to no table, clamp past last charge entry
      add_sample(0, 0, 0);            // first sample seeds shown value
      add_sample(0, 8191, 4095);      // above discharge table
      add_sample(0, 3800, 100);
      add_sample(1, 0, 0);
      add_sample(1, 4160, 4095);      // past the last charge entry, flat segment
      add_write(TBL_UNUSED, 7, 8191, 100);
      add_sample(1, 8191, 0);
      for (i = 0; i < 12; i++) add_sample(1, 4250, 500);  // climb to full
      add_sample(0, 4000, 0);
      add_sample(0, 3350, 0);
      wait_idle();

      // phase 1: no idling, small targets, current sensing
      write_reg(bcspg_pkg::REG_FULL_TARGET, 1);
      write_reg(bcspg_pkg::REG_TRICKLE_TARGET, 3);
      write_reg(bcspg_pkg::REG_TRICKLE_MV, 3900);
      write_reg(bcspg_pkg::REG_CUR_SENSE, 1);
      write_reg(bcspg_pkg::REG_CPOINTS, 1);
      random_traffic(300);
      wait_idle();

      // phase 2: sender idles, largest targets, threshold extremes
      send_idle_pct = 57;
      write_reg(bcspg_pkg::REG_FULL_TARGET, 65535);
      write_reg(bcspg_pkg::REG_TRICKLE_TARGET, 65535);
      write_reg(bcspg_pkg::REG_TRICKLE_MV, 0);
      write_reg(bcspg_pkg::REG_FULL_MV, 8191);
      write_reg(bcspg_pkg::REG_VPOINTS, 2);
      write_reg(bcspg_pkg::REG_CPOINTS, 8);
      random_traffic(300);
      wait_idle();

      // phase 3: receiver stalls, with one long hold-off to fill the block
      send_idle_pct = 0;
      stall_pct = 57;
      write_reg(bcspg_pkg::REG_FULL_TARGET, 6);
      write_reg(bcspg_pkg::REG_TRICKLE_TARGET, 1);
      write_reg(bcspg_pkg::REG_TRICKLE_MV, 8191);
      write_reg(bcspg_pkg::REG_FULL_MV, 0);
      write_reg(bcspg_pkg::REG_FULL_RULE, 0);
      write_reg(bcspg_pkg::REG_VPOINTS, 8);
      @(posedge clock);
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      random_traffic(300);
      wait_idle();

      // phase 4: both sides idle
      send_idle_pct = 21;
      stall_pct = 21;
      write_reg(bcspg_pkg::REG_FULL_TARGET, 4);
      write_reg(bcspg_pkg::REG_TRICKLE_TARGET, 4);
      write_reg(bcspg_pkg::REG_TRICKLE_MV, 4000);
      write_reg(bcspg_pkg::REG_FULL_MV, 4200);
      write_reg(bcspg_pkg::REG_FULL_RULE, 1);
      write_reg(bcspg_pkg::REG_CUR_SENSE, 0);
      write_reg(bcspg_pkg::REG_VPOINTS, 5);
      random_traffic(300);
      wait_idle();

      // phase 5: mixed, current sensing with partial table
      send_idle_pct = 10;
      stall_pct = 30;
      write_reg(bcspg_pkg::REG_CUR_SENSE, 1);
      write_reg(bcspg_pkg::REG_CPOINTS, 4);
      write_reg(bcspg_pkg::REG_FULL_TARGET, 8);
      random_traffic(280);
      wait_idle();

      $display("covered %0d samples and %0d table writes over five register settings,",
               n_samples, n_writes);
      $display("%0d results checked, %0d in the charge full state", n_results, n_full);
      if (errors == 0)
         $display("battery_charge_state_percent_gauge_top regression: pass");
      else
         $display("battery_charge_state_percent_gauge_top regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #40000000;
      $display("timeout waiting for the gauge");
      $display("battery_charge_state_percent_gauge_top regression: fail");
      $finish;
   end

endmodule
